// ----- rtl/core/prwc_pkg.sv -----
// Shared types and constants for the polygon ring winding check.
// Used by the channel interfaces and by the top level; no dependencies.
package prwc_pkg;

  localparam int COORD_W           = 32;
  localparam int AREA_W            = 48;
  localparam int MIN_RING_VERTICES = 3;

  typedef logic signed [COORD_W-1:0] coord_t;
  typedef logic signed [AREA_W-1:0]  area_t;

  typedef logic [1:0] status_t;
  localparam status_t ST_OK       = 2'd0;
  localparam status_t ST_SHORT    = 2'd1;
  localparam status_t ST_OUTER_CW = 2'd2;
  localparam status_t ST_HOLE_CCW = 2'd3;

  typedef struct packed {
    coord_t min_x;
    coord_t min_y;
    coord_t max_x;
    coord_t max_y;
  } box_t;

endpackage

// ----- rtl/core/prwc_ifs.sv -----
// Valid/ready channels of the polygon ring winding check: vertex requests in,
// ring results out. Depends on prwc_pkg.
interface prwc_vertex_if;
  logic             valid;
  logic             ready;
  prwc_pkg::coord_t vertex_x;
  prwc_pkg::coord_t vertex_y;
  logic             ring_is_hole;
  logic             last_vertex;

  modport source (output valid, vertex_x, vertex_y, ring_is_hole, last_vertex, input ready);
  modport sink   (input valid, vertex_x, vertex_y, ring_is_hole, last_vertex, output ready);
endinterface

interface prwc_result_if #(
  parameter int MAX_VERTICES = 4096
);
  localparam int CNT_W = $clog2(MAX_VERTICES + 1);

  logic               valid;
  logic               ready;
  prwc_pkg::area_t    signed_area;
  logic [CNT_W-1:0]   vertex_total;
  logic               needs_reverse;
  prwc_pkg::status_t  status;
  prwc_pkg::coord_t   box_min_x;
  prwc_pkg::coord_t   box_min_y;
  prwc_pkg::coord_t   box_max_x;
  prwc_pkg::coord_t   box_max_y;

  modport source (output valid, signed_area, vertex_total, needs_reverse, status,
                  box_min_x, box_min_y, box_max_x, box_max_y, input ready);
  modport sink   (input valid, signed_area, vertex_total, needs_reverse, status,
                  box_min_x, box_min_y, box_max_x, box_max_y, output ready);
endinterface

// ----- rtl/core/polygon_ring_winding_check.sv -----
// Polygon ring winding check: shoelace signed area, vertex count, winding status and
// bounding box of one ring. Depends on prwc_pkg and the interfaces in prwc_ifs.sv.
//
// One vertex request is accepted per clock cycle unless the input stalls. Each vertex
// passes an input register, a product stage (two cross products per vertex: step edge
// and closing edge, four multipliers of integer-part width) and an accumulate stage,
// then the result register, which takes a ring's result as its last vertex leaves the
// accumulate stage. Vertices that do not close a ring produce no result. Backpressure
// on the result side only stalls the input once every stage holds a request.
module polygon_ring_winding_check #(
  parameter int MAX_VERTICES  = 4096,
  parameter int FRACTION_BITS = 16
) (
  input  logic                 clk,
  input  logic                 rst,
  prwc_vertex_if.sink          vertex,
  prwc_result_if.source        result
);

  localparam int IW    = prwc_pkg::COORD_W - FRACTION_BITS;
  localparam int CNT_W = $clog2(MAX_VERTICES + 1);

  // Input register.
  logic             r1_valid;
  prwc_pkg::coord_t r1_x;
  prwc_pkg::coord_t r1_y;
  logic             r1_hole;
  logic             r1_last;

  // Ring state, updated as a vertex leaves the input register.
  logic signed [IW-1:0] first_x;
  logic signed [IW-1:0] first_y;
  logic signed [IW-1:0] prev_x;
  logic signed [IW-1:0] prev_y;
  logic [CNT_W-1:0]     points_seen;
  prwc_pkg::box_t       box;

  // Product stage register.
  logic             r2_valid;
  logic             r2_last;
  logic             r2_hole;
  prwc_pkg::area_t  r2_step;
  prwc_pkg::area_t  r2_close;
  logic [CNT_W-1:0] r2_count;
  prwc_pkg::box_t   r2_box;

  prwc_pkg::area_t  area_acc;

  // Result register.
  logic             out_valid;
  prwc_pkg::area_t  out_area;
  logic [CNT_W-1:0] out_count;
  logic             out_reverse;
  prwc_pkg::status_t out_status;
  prwc_pkg::box_t   out_box;

  logic r2_take;
  logic r1_move;
  logic in_take;

  // A non-closing vertex leaves the accumulate stage without needing the result register.
  assign r2_take = r2_valid && (!r2_last || !out_valid || result.ready);
  assign r1_move = r1_valid && (!r2_valid || r2_take);
  assign vertex.ready = !r1_valid || r1_move;
  assign in_take = vertex.valid && vertex.ready;

  // Product stage logic.
  logic signed [IW-1:0]   ix;
  logic signed [IW-1:0]   iy;
  logic                   is_first;
  logic signed [IW-1:0]   fx;
  logic signed [IW-1:0]   fy;
  logic signed [2*IW-1:0] pa;
  logic signed [2*IW-1:0] pb;
  logic signed [2*IW-1:0] qa;
  logic signed [2*IW-1:0] qb;
  logic [CNT_W-1:0]       count_next;
  prwc_pkg::box_t         box_next;

  always_comb begin
    ix       = IW'(r1_x >>> FRACTION_BITS);
    iy       = IW'(r1_y >>> FRACTION_BITS);
    is_first = (points_seen == '0);
    fx       = is_first ? ix : first_x;
    fy       = is_first ? iy : first_y;
    pa       = prev_x * iy;
    pb       = ix * prev_y;
    qa       = ix * fy;
    qb       = fx * iy;
    if (points_seen < CNT_W'(MAX_VERTICES)) begin
      count_next = points_seen + CNT_W'(1);
    end else begin
      count_next = points_seen;
    end
    if (is_first) begin
      box_next = '{min_x: r1_x, min_y: r1_y, max_x: r1_x, max_y: r1_y};
    end else begin
      box_next = box;
      if (r1_x < box.min_x) box_next.min_x = r1_x;
      if (r1_y < box.min_y) box_next.min_y = r1_y;
      if (r1_x > box.max_x) box_next.max_x = r1_x;
      if (r1_y > box.max_y) box_next.max_y = r1_y;
    end
  end

  // Accumulate stage logic.
  prwc_pkg::area_t   acc_next;
  prwc_pkg::area_t   area;
  prwc_pkg::status_t status_next;
  logic              reverse_next;

  always_comb begin
    acc_next     = area_acc + r2_step;
    area         = acc_next + r2_close;
    status_next  = prwc_pkg::ST_OK;
    reverse_next = 1'b0;
    if (r2_count < CNT_W'(prwc_pkg::MIN_RING_VERTICES)) begin
      area        = '0;
      status_next = prwc_pkg::ST_SHORT;
    end else if (area != '0) begin
      if (!r2_hole && area[prwc_pkg::AREA_W-1]) begin
        status_next  = prwc_pkg::ST_OUTER_CW;
        reverse_next = 1'b1;
      end else if (r2_hole && !area[prwc_pkg::AREA_W-1]) begin
        status_next  = prwc_pkg::ST_HOLE_CCW;
        reverse_next = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      r1_valid    <= 1'b0;
      r2_valid    <= 1'b0;
      out_valid   <= 1'b0;
      points_seen <= '0;
      area_acc    <= '0;
    end else begin
      if (in_take) begin
        r1_valid <= 1'b1;
      end else if (r1_move) begin
        r1_valid <= 1'b0;
      end

      if (r1_move) begin
        r2_valid <= 1'b1;
      end else if (r2_take) begin
        r2_valid <= 1'b0;
      end

      if (r1_move) begin
        points_seen <= r1_last ? '0 : count_next;
      end

      if (r2_take) begin
        area_acc <= r2_last ? '0 : acc_next;
      end

      if (r2_take && r2_last) begin
        out_valid <= 1'b1;
      end else if (result.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      r1_x    <= vertex.vertex_x;
      r1_y    <= vertex.vertex_y;
      r1_hole <= vertex.ring_is_hole;
      r1_last <= vertex.last_vertex;
    end
    if (r1_move) begin
      if (is_first) begin
        first_x <= ix;
        first_y <= iy;
      end
      prev_x   <= ix;
      prev_y   <= iy;
      box      <= box_next;
      r2_last  <= r1_last;
      r2_hole  <= r1_hole;
      r2_step  <= is_first ? '0 : prwc_pkg::area_t'(pa) - prwc_pkg::area_t'(pb);
      r2_close <= prwc_pkg::area_t'(qa) - prwc_pkg::area_t'(qb);
      r2_count <= count_next;
      r2_box   <= box_next;
    end
    if (r2_take && r2_last) begin
      out_area    <= area;
      out_count   <= r2_count;
      out_reverse <= reverse_next;
      out_status  <= status_next;
      out_box     <= r2_box;
    end
  end

  assign result.valid         = out_valid;
  assign result.signed_area   = out_area;
  assign result.vertex_total  = out_count;
  assign result.needs_reverse = out_reverse;
  assign result.status        = out_status;
  assign result.box_min_x     = out_box.min_x;
  assign result.box_min_y     = out_box.min_y;
  assign result.box_max_x     = out_box.max_x;
  assign result.box_max_y     = out_box.max_y;

endmodule
